/* sv/rsi_pkg.sv */
package rsi_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;

    // Internal widths (all exact, nothing can overflow)
    localparam int OX_W   = 33;            // origin minus center, signed
    localparam int OXM_W  = 33;            // magnitude of that difference
    localparam int DM_W   = 32;            // magnitude of a direction component
    localparam int PROD_W = 65;            // one component product magnitude
    localparam int A_W    = 64;            // a = d.d, unsigned
    localparam int H_W    = 67;            // h = (o-C).d, signed
    localparam int HM_W   = 66;            // |h|
    localparam int C_W    = 68;            // c = |o-C|^2 - r^2, signed
    localparam int CM_W   = 67;            // |c|
    localparam int HH_W   = 2 * HM_W;      // h*h
    localparam int AC_W   = A_W + CM_W;    // a*|c|
    localparam int DISC_W = HH_W;          // nonnegative discriminant
    localparam int S_W    = DISC_W / 2;    // floor square root
    localparam int N_W    = 68;            // -h -/+ s, signed
    localparam int NM_W   = 67;            // magnitude of the numerator
    localparam int Q_W    = 32;            // quotient bits kept before saturation

    localparam logic [RAD_W-1:0] RADIUS_RESET = 31'd65536;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

    // Side-band bundles that ride along the arithmetic units
    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic                  c_neg;
        logic                  a_zero;
    } mul_side_t;

    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic                  miss;
    } root_side_t;

    typedef struct packed {
        logic neg;
        logic miss;
    } div_side_t;

endpackage

/* sv/rsi_ifs.sv */
interface rsi_ray_if;
    logic                    valid;
    logic                    ready;
    logic signed [32-1:0]    origin_x;
    logic signed [32-1:0]    origin_y;
    logic signed [32-1:0]    origin_z;
    logic signed [32-1:0]    dir_x;
    logic signed [32-1:0]    dir_y;
    logic signed [32-1:0]    dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rsi_hit_if;
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [32-1:0]    distance;

    modport source (output valid, hit, distance, input ready);
    modport sink   (input valid, hit, distance, output ready);
endinterface

/* sv/rsi_mul.sv */
module rsi_mul #(
    parameter int AW = 66,
    parameter int BW = 66
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [AW-1:0]     a,
    input  logic [BW-1:0]     b,
    output logic              out_valid,
    output logic [AW+BW-1:0]  p
);

    localparam int LW   = 32;
    localparam int NA   = (AW + LW - 1) / LW;
    localparam int NB   = (BW + LW - 1) / LW;
    localparam int PW   = AW + BW;
    localparam int RW   = (NB + 1) * LW;
    localparam int SUMW = (NA + NB) * LW;

    logic [NA*LW-1:0]  a_ext;
    logic [NB*LW-1:0]  b_ext;
    logic [2*LW-1:0]   pp_reg  [NA][NB];
    logic [2*LW-1:0]   pp_next [NA][NB];
    logic [RW-1:0]     row_reg  [NA];
    logic [RW-1:0]     row_next [NA];
    logic [SUMW-1:0]   sum_next;
    logic [PW-1:0]     p_reg;
    logic [2:0]        v_reg;

    assign a_ext = (NA*LW)'(a);
    assign b_ext = (NB*LW)'(b);

    // Stage 1: limb partial products, 32x32 each
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i][j] = (2*LW)'(a_ext[i*LW +: LW]) * (2*LW)'(b_ext[j*LW +: LW]);
            end
        end
    end

    // Stage 2: one row per limb of a
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j * LW));
            end
        end
    end

    // Stage 3: rows summed into the product
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            sum_next = sum_next + (SUMW'(row_reg[i]) << (i * LW));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg  <= pp_next;
            row_reg <= row_next;
            p_reg   <= PW'(sum_next);
        end
    end

    assign out_valid = v_reg[2];
    assign p         = p_reg;

endmodule

/* sv/rsi_sqrt.sv */
module rsi_sqrt #(
    parameter int DW = 132,
    parameter int SW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DW-1:0]      rad,
    input  logic [SW-1:0]      side_in,
    output logic               out_valid,
    output logic [DW/2-1:0]    root,
    output logic [SW-1:0]      side_out
);

    localparam int RW = DW / 2;
    localparam int TW = RW + 3;
    localparam int ST = RW;

    logic [DW-1:0] rad_reg  [ST];
    logic [DW-1:0] rad_next [ST];
    logic [TW-1:0] rem_reg  [ST];
    logic [TW-1:0] rem_next [ST];
    logic [RW-1:0] root_reg  [ST];
    logic [RW-1:0] root_next [ST];
    logic [SW-1:0] side_reg [ST];
    logic [ST-1:0] v_reg;

    // One result bit per stage: restoring digit recurrence
    always_comb
    begin
        logic [DW-1:0] r_in;
        logic [TW-1:0] m_in;
        logic [RW-1:0] q_in;
        logic [TW-1:0] trial;
        logic [TW-1:0] cand;
        for (int k = 0; k < ST; k++)
        begin
            if (k == 0)
            begin
                r_in = rad;
                m_in = '0;
                q_in = '0;
            end
            else
            begin
                r_in = rad_reg[k-1];
                m_in = rem_reg[k-1];
                q_in = root_reg[k-1];
            end
            trial = {m_in[TW-3:0], r_in[DW-1 -: 2]};
            cand  = TW'({q_in, 2'b01});
            if (trial >= cand)
            begin
                rem_next[k]  = trial - cand;
                root_next[k] = {q_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = trial;
                root_next[k] = {q_in[RW-2:0], 1'b0};
            end
            rad_next[k] = r_in << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg[0] <= side_in;
            for (int k = 1; k < ST; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[ST-1];
    assign root      = root_reg[ST-1];
    assign side_out  = side_reg[ST-1];

endmodule

/* sv/rsi_div.sv */
module rsi_div #(
    parameter int NW  = 83,
    parameter int DVW = 64,
    parameter int QW  = 32,
    parameter int SW  = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   num,
    input  logic [DVW-1:0]  dv,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [QW-1:0]   quo,
    output logic            ovf,
    output logic [SW-1:0]   side_out
);

    localparam int CW = (NW > DVW + QW) ? NW : DVW + QW;
    localparam int ST = QW + 1;

    logic [NW-1:0]  rem_reg  [ST];
    logic [NW-1:0]  rem_next [ST];
    logic [DVW-1:0] dv_reg   [ST];
    logic [QW-1:0]  q_reg    [ST];
    logic [QW-1:0]  q_next   [ST];
    logic           ovf_reg  [ST];
    logic           ovf_next;
    logic [SW-1:0]  side_reg [ST];
    logic [ST-1:0]  v_reg;

    // First stage flags a quotient that does not fit in QW bits;
    // each later stage settles one quotient bit, MSB first
    always_comb
    begin
        logic [CW-1:0] shd;
        int b;
        ovf_next    = CW'(num) >= (CW'(dv) << QW);
        rem_next[0] = num;
        q_next[0]   = '0;
        for (int k = 1; k < ST; k++)
        begin
            b   = QW - k;
            shd = CW'(dv_reg[k-1]) << b;
            if (CW'(rem_reg[k-1]) >= shd)
            begin
                rem_next[k] = NW'(CW'(rem_reg[k-1]) - shd);
                q_next[k]   = q_reg[k-1] | (QW'(1) << b);
            end
            else
            begin
                rem_next[k] = rem_reg[k-1];
                q_next[k]   = q_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            dv_reg[0]   <= dv;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side_in;
            for (int k = 1; k < ST; k++)
            begin
                dv_reg[k]   <= dv_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[ST-1];
    assign quo       = q_reg[ST-1];
    assign ovf       = ovf_reg[ST-1];
    assign side_out  = side_reg[ST-1];

endmodule

/* sv/ray_sphere_intersect_unit.sv */
// Ray-sphere intersection, fully pipelined.
// The 66-stage square root and the 33-stage divider make up most of the
// pipeline depth.
// Throughput: one ray per cycle; the whole pipeline holds while a result waits.
// Reset: asynchronous, active low; clears all valid bits, center to 0, radius to 1.0.
module ray_sphere_intersect_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsi_pkg::COORD_W-1:0]      cfg_data,
    rsi_ray_if.sink                          ray,
    rsi_hit_if.source                        result
);

    import rsi_pkg::*;

    localparam int NUM_W = NM_W + FRAC_BITS;

    // Configuration registers
    logic signed [COORD_W-1:0] cen_reg [3];
    logic [RAD_W-1:0]          rad_reg;

    // Pipeline advance
    logic adv;

    // Input capture
    logic                      v0_reg;
    logic signed [COORD_W-1:0] o_reg [3];
    logic signed [COORD_W-1:0] d_reg [3];

    // Offsets and magnitudes
    logic                      v1_reg;
    logic [OXM_W-1:0]          oxm_reg [3];
    logic [OXM_W-1:0]          oxm_next [3];
    logic                      oxn_reg [3];
    logic [DM_W-1:0]           dm_reg [3];
    logic [DM_W-1:0]           dm_next [3];
    logic                      dn_reg [3];
    logic [RAD_W-1:0]          r1_reg;

    // Component products
    logic                      v2_reg;
    logic [PROD_W-1:0]         pdd_reg [3];
    logic [PROD_W-1:0]         pod_reg [3];
    logic [PROD_W-1:0]         poo_reg [3];
    logic                      pn_reg [3];
    logic [PROD_W-1:0]         prr_reg;

    // Coefficients
    logic                      v3_reg;
    logic [A_W-1:0]            a3_reg;
    logic [A_W-1:0]            a3_next;
    logic signed [H_W-1:0]     h3_reg;
    logic signed [H_W-1:0]     h3_next;
    logic signed [C_W-1:0]     c3_reg;
    logic signed [C_W-1:0]     c3_next;

    // Magnitudes into the wide multipliers
    logic                      v4_reg;
    logic [HM_W-1:0]           hm4_reg;
    logic [CM_W-1:0]           cm4_reg;
    mul_side_t                 ms4_reg;

    logic                      mul_v;
    logic                      mul_v_ac;
    logic [HH_W-1:0]           hh;
    logic [AC_W-1:0]           ac;
    mul_side_t                 ms_reg [3];

    // Discriminant
    logic                      v8_reg;
    logic [DISC_W-1:0]         disc8_reg;
    root_side_t                rs8_reg;
    root_side_t                rs8_next;
    logic [DISC_W:0]           dsum;

    logic                      sq_v;
    logic [S_W-1:0]            sq_root;
    logic [$bits(root_side_t)-1:0] sq_side_raw;
    root_side_t                sq_side;

    // Numerators
    logic                      v9_reg;
    logic signed [N_W-1:0]     n1_reg;
    logic signed [N_W-1:0]     n2_reg;
    logic [A_W-1:0]            a9_reg;
    logic                      miss9_reg;
    logic signed [N_W-1:0]     nh;
    logic signed [N_W-1:0]     sv;

    // Root choice and divider operands
    logic                      v10_reg;
    logic [NUM_W-1:0]          nm10_reg;
    logic [A_W-1:0]            a10_reg;
    div_side_t                 ds10_reg;
    logic                      n1_pos;
    logic                      sel1;
    logic signed [N_W-1:0]     num_s;
    logic signed [N_W-1:0]     mag_s;

    logic                      dv_v;
    logic [Q_W-1:0]            quo;
    logic                      quo_ovf;
    logic [$bits(div_side_t)-1:0] dv_side_raw;
    div_side_t                 dv_side;

    // Result register
    logic                      ov_reg;
    logic                      hit_reg;
    logic signed [COORD_W-1:0] dist_reg;
    logic signed [COORD_W-1:0] dist_next;
    logic                      sat;

    assign adv       = !ov_reg || result.ready;
    assign ray.ready = adv;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_reg[0] <= '0;
            cen_reg[1] <= '0;
            cen_reg[2] <= '0;
            rad_reg    <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_X: cen_reg[0] <= cfg_data;
                CFG_CENTER_Y: cen_reg[1] <= cfg_data;
                CFG_CENTER_Z: cen_reg[2] <= cfg_data;
                CFG_RADIUS:   rad_reg    <= cfg_data[RAD_W-1:0];
            endcase
        end
    end

    // Offset from center, split into sign and magnitude
    always_comb
    begin
        logic signed [OX_W-1:0] ox;
        for (int i = 0; i < 3; i++)
        begin
            ox          = OX_W'(o_reg[i]) - OX_W'(cen_reg[i]);
            oxm_next[i] = ox[OX_W-1] ? OXM_W'(-ox) : OXM_W'(ox);
            dm_next[i]  = d_reg[i][COORD_W-1] ? DM_W'(-d_reg[i]) : DM_W'(d_reg[i]);
        end
    end

    // a, h and c from the component products
    always_comb
    begin
        logic signed [H_W-1:0] t;
        a3_next = A_W'(pdd_reg[0] + pdd_reg[1] + pdd_reg[2]);
        h3_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            t = $signed(H_W'(pod_reg[i]));
            if (pn_reg[i])
            begin
                t = -t;
            end
            h3_next = h3_next + t;
        end
        c3_next = $signed(C_W'(poo_reg[0])) + $signed(C_W'(poo_reg[1]))
                + $signed(C_W'(poo_reg[2])) - $signed(C_W'(prr_reg));
    end

    // h*h and a*|c|
    rsi_mul #(.AW(HM_W), .BW(HM_W)) u_mul_hh (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v4_reg),
        .a         (hm4_reg),
        .b         (hm4_reg),
        .out_valid (mul_v),
        .p         (hh)
    );

    rsi_mul #(.AW(A_W), .BW(CM_W)) u_mul_ac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v4_reg),
        .a         (ms4_reg.a),
        .b         (cm4_reg),
        .out_valid (mul_v_ac),
        .p         (ac)
    );

    // disc = h*h - a*c; sign of c picks add or subtract
    always_comb
    begin
        if (ms_reg[2].c_neg)
        begin
            dsum = (DISC_W+1)'(hh) + (DISC_W+1)'(ac);
        end
        else
        begin
            dsum = (DISC_W+1)'(hh) - (DISC_W+1)'(ac);
        end
        rs8_next.h    = ms_reg[2].h;
        rs8_next.a    = ms_reg[2].a;
        rs8_next.miss = ms_reg[2].a_zero || dsum[DISC_W] || !mul_v_ac;
    end

    rsi_sqrt #(.DW(DISC_W), .SW($bits(root_side_t))) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v8_reg),
        .rad       (disc8_reg),
        .side_in   (rs8_reg),
        .out_valid (sq_v),
        .root      (sq_root),
        .side_out  (sq_side_raw)
    );

    assign sq_side = root_side_t'(sq_side_raw);
    assign nh      = -N_W'(sq_side.h);
    assign sv      = $signed(N_W'(sq_root));

    // Pick the near root when it lies ahead, else the far root
    always_comb
    begin
        n1_pos = !n1_reg[N_W-1] && (n1_reg != '0);
        sel1   = n1_pos && ((NUM_W'(n1_reg[NM_W-1:0]) << FRAC_BITS) >= NUM_W'(a9_reg));
        num_s  = sel1 ? n1_reg : n2_reg;
        mag_s  = num_s[N_W-1] ? -num_s : num_s;
    end

    rsi_div #(.NW(NUM_W), .DVW(A_W), .QW(Q_W), .SW($bits(div_side_t))) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v10_reg),
        .num       (nm10_reg),
        .dv        (a10_reg),
        .side_in   (ds10_reg),
        .out_valid (dv_v),
        .quo       (quo),
        .ovf       (quo_ovf),
        .side_out  (dv_side_raw)
    );

    assign dv_side = div_side_t'(dv_side_raw);

    // Sign and saturation of the distance
    always_comb
    begin
        sat = quo_ovf || quo[Q_W-1];
        if (dv_side.miss)
        begin
            dist_next = '0;
        end
        else if (dv_side.neg)
        begin
            dist_next = sat ? $signed(32'h8000_0000) : -$signed(COORD_W'(quo));
        end
        else
        begin
            dist_next = sat ? $signed(32'h7FFF_FFFF) : $signed(COORD_W'(quo));
        end
    end

    // Valid bits of the top-level stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg  <= ray.valid;
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v8_reg  <= mul_v;
            v9_reg  <= sq_v;
            v10_reg <= v9_reg;
            ov_reg  <= dv_v;
        end
    end

    // Payload of the top-level stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_reg[0] <= ray.origin_x;
            o_reg[1] <= ray.origin_y;
            o_reg[2] <= ray.origin_z;
            d_reg[0] <= ray.dir_x;
            d_reg[1] <= ray.dir_y;
            d_reg[2] <= ray.dir_z;

            for (int i = 0; i < 3; i++)
            begin
                oxm_reg[i] <= oxm_next[i];
                oxn_reg[i] <= o_reg[i] < cen_reg[i];
                dm_reg[i]  <= dm_next[i];
                dn_reg[i]  <= d_reg[i][COORD_W-1];

                pdd_reg[i] <= PROD_W'(dm_reg[i]) * PROD_W'(dm_reg[i]);
                pod_reg[i] <= PROD_W'(oxm_reg[i]) * PROD_W'(dm_reg[i]);
                poo_reg[i] <= PROD_W'(oxm_reg[i]) * PROD_W'(oxm_reg[i]);
                pn_reg[i]  <= oxn_reg[i] ^ dn_reg[i];
            end
            r1_reg  <= rad_reg;
            prr_reg <= PROD_W'(r1_reg) * PROD_W'(r1_reg);

            a3_reg <= a3_next;
            h3_reg <= h3_next;
            c3_reg <= c3_next;

            hm4_reg        <= h3_reg[H_W-1] ? HM_W'(-h3_reg) : HM_W'(h3_reg);
            cm4_reg        <= c3_reg[C_W-1] ? CM_W'(-c3_reg) : CM_W'(c3_reg);
            ms4_reg.h      <= h3_reg;
            ms4_reg.a      <= a3_reg;
            ms4_reg.c_neg  <= c3_reg[C_W-1];
            ms4_reg.a_zero <= (a3_reg == '0);

            ms_reg[0] <= ms4_reg;
            ms_reg[1] <= ms_reg[0];
            ms_reg[2] <= ms_reg[1];

            disc8_reg <= dsum[DISC_W-1:0];
            rs8_reg   <= rs8_next;

            n1_reg    <= nh - sv;
            n2_reg    <= nh + sv;
            a9_reg    <= sq_side.a;
            miss9_reg <= sq_side.miss;

            nm10_reg      <= NUM_W'(mag_s[NM_W-1:0]) << FRAC_BITS;
            a10_reg       <= a9_reg;
            ds10_reg.neg  <= num_s[N_W-1];
            ds10_reg.miss <= miss9_reg;

            hit_reg  <= !dv_side.miss;
            dist_reg <= dist_next;
        end
    end

    assign result.valid    = ov_reg;
    assign result.hit      = hit_reg;
    assign result.distance = dist_reg;

endmodule
